// ===== hw/rtl/alpha_weighted_box_downsample_unit_assert.svh =====
// Assertion macros for the alpha weighted box downsample unit.
// Used by the top level only; needs nothing else.
`ifndef ALPHA_WEIGHTED_BOX_DOWNSAMPLE_UNIT_ASSERT_SVH
`define ALPHA_WEIGHTED_BOX_DOWNSAMPLE_UNIT_ASSERT_SVH
`define AWB_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define AWB_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/awbd_pkg.sv =====
// Package of the alpha weighted box downsample unit: types and constants.
// Used by all modules; depends on nothing.
`timescale 1ns / 1ps
package awbd_pkg;
    localparam int MAX_TARGET_WIDTH = 1024;
    localparam int MAX_SCALE = 16;
    localparam int COL_W = $clog2(MAX_TARGET_WIDTH);
    localparam int SC_W = $clog2(MAX_SCALE + 1);
    localparam int SUM_W = 24;
    localparam int ASUM_W = 16;
    localparam logic [2:0] REG_SX = 3'd0;
    localparam logic [2:0] REG_SY = 3'd1;
    localparam logic [2:0] REG_TW = 3'd2;
    localparam logic [2:0] REG_TH = 3'd3;
    localparam logic [2:0] REG_THR = 3'd4;
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_OUT
    } t_state;
    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
        logic [ASUM_W-1:0] alpha;
    } t_sums;
endpackage

// ===== hw/rtl/awbd_sum_ram.sv =====
// Column sum memory with a registered read port.
// Depends on awbd_pkg.
`timescale 1ns / 1ps
module awbd_sum_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [awbd_pkg::COL_W-1:0] i_waddr,
    input  awbd_pkg::t_sums           i_wdata,
    input  logic [awbd_pkg::COL_W-1:0] i_raddr,
    output awbd_pkg::t_sums           o_rdata
);
    import awbd_pkg::*;
    t_sums r_mem [MAX_TARGET_WIDTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/awbd_divider.sv =====
// Restoring divider: three 24 bit colour sums by one 16 bit alpha sum, one bit a cycle.
// Depends on awbd_pkg.
`timescale 1ns / 1ps
module awbd_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  awbd_pkg::t_sums               i_sums,
    output logic                          o_done,
    output logic [7:0]                    o_red,
    output logic [7:0]                    o_green,
    output logic [7:0]                    o_blue
);
    import awbd_pkg::*;
    logic [4:0] r_cnt;
    logic r_busy;
    logic [SUM_W-1:0] r_q [3];
    logic [ASUM_W:0] r_rem [3];
    logic [ASUM_W-1:0] r_den;
    logic [ASUM_W:0] n_rem [3];
    logic n_bit [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_rem[k] = {r_rem[k][ASUM_W-1:0], r_q[k][SUM_W-1]};
            n_bit[k] = n_rem[k] >= {1'b0, r_den};
            if (n_bit[k]) begin
                n_rem[k] = n_rem[k] - {1'b0, r_den};
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 5'(SUM_W - 1);
            end else if (r_busy) begin
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q[0] <= i_sums.red;
            r_q[1] <= i_sums.green;
            r_q[2] <= i_sums.blue;
            r_den <= i_sums.alpha;
            for (int k = 0; k < 3; k++) r_rem[k] <= '0;
        end else if (r_busy) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k] <= {r_q[k][SUM_W-2:0], n_bit[k]};
            end
        end
    end
    assign o_red = r_q[0][7:0];
    assign o_green = r_q[1][7:0];
    assign o_blue = r_q[2][7:0];
endmodule

// ===== hw/rtl/alpha_weighted_box_downsample_unit.sv =====
// Top level of the alpha weighted box downsampler: counters, sequencer, output register.
// Depends on awbd_pkg, awbd_sum_ram, awbd_divider and the assertion header.
//
//  channel | direction | handshake       | payload
//  pixel   | in        | valid / stall   | red green blue alpha
//  result  | out       | valid / stall   | out_* and frame_end
//  config  | in        | valid / ready   | index, data
//
// A word that does not end a block goes through memory read, then write back.
// A word that ends an uncovered block then goes to output without the divider; one that
// ends a covered block waits for the 24 step bit serial divider.
// Reset is synchronous; the sum memory is never cleared, since the first pixel of each
// block column overwrites its sums. A stalled result stays in the output register until
// taken; new pixels are taken meanwhile, and the next finished block waits until it frees.
`timescale 1ns / 1ps
`include "alpha_weighted_box_downsample_unit_assert.svh"
module alpha_weighted_box_downsample_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_alpha,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_alpha,
    output logic [9:0]  o_out_column,
    output logic [9:0]  o_out_row,
    output logic        o_frame_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);
    import awbd_pkg::*;
    t_state r_state, n_state;
    logic [4:0] r_sx_raw, r_sy_raw;
    logic [10:0] r_tw_raw, r_th_raw;
    logic [16:0] r_thr;
    logic [SC_W-1:0] w_sx, w_sy;
    logic [10:0] w_tw, w_th;
    logic [COL_W-1:0] r_col;
    logic [SC_W-1:0] r_offx, r_rib;
    logic [9:0] r_trow;
    logic [15:0] r_pr, r_pg, r_pb;
    logic [7:0] r_pa;
    logic r_first, r_last;
    logic [COL_W-1:0] r_bcol;
    logic [9:0] r_brow;
    logic r_bend;
    logic [16:0] r_max;
    logic [33:0] r_rhs;
    t_sums w_rd, w_wd, r_sum;
    logic w_cov, w_accept, w_we, w_div_start, w_div_done;
    logic [7:0] w_dr, w_dg, w_db;
    logic w_out_free;
    logic r_stage;
    logic w_cfg_hit;
    logic r_done_hold, r_res_cov;
    always_comb begin
        w_sx = (r_sx_raw == 5'd0) ? SC_W'(1) : (r_sx_raw > 5'(MAX_SCALE)) ? SC_W'(MAX_SCALE)
                                                                     : SC_W'(r_sx_raw);
        w_sy = (r_sy_raw == 5'd0) ? SC_W'(1) : (r_sy_raw > 5'(MAX_SCALE)) ? SC_W'(MAX_SCALE)
                                                                     : SC_W'(r_sy_raw);
        w_tw = (r_tw_raw == 11'd0) ? 11'd1 : (r_tw_raw > 11'(MAX_TARGET_WIDTH))
               ? 11'(MAX_TARGET_WIDTH) : r_tw_raw;
        w_th = (r_th_raw == 11'd0) ? 11'd1 : (r_th_raw > 11'd1024) ? 11'd1024 : r_th_raw;
    end
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign w_out_free = !o_valid || !i_stall;
    assign o_stall = (r_state != ST_IDLE) || i_cfg_valid;
    assign w_accept = i_valid && !o_stall;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx_raw <= 5'd1;
            r_sy_raw <= 5'd1;
            r_tw_raw <= 11'd1;
            r_th_raw <= 11'd1;
            r_thr <= 17'd32768;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SX: r_sx_raw <= i_cfg_data[4:0];
                REG_SY: r_sy_raw <= i_cfg_data[4:0];
                REG_TW: r_tw_raw <= i_cfg_data[10:0];
                REG_TH: r_th_raw <= i_cfg_data[10:0];
                REG_THR: r_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end
    always_ff @(posedge i_clk) begin
        r_max <= 17'(w_sx) * 17'(w_sy) * 17'd255;
        r_rhs <= r_max * r_thr;
    end
    assign w_cfg_hit = i_cfg_valid && o_cfg_ready && (i_cfg_index inside {REG_SX, REG_SY,
                       REG_TW, REG_TH, REG_THR});
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_hit) begin
            r_col <= '0;
            r_offx <= '0;
            r_rib <= '0;
            r_trow <= '0;
        end else if (w_accept) begin
            r_bcol <= r_col;
            r_brow <= r_trow;
            r_bend <= (11'(r_col) == w_tw - 11'd1) && (11'(r_trow) == w_th - 11'd1);
            r_first <= (r_rib == '0) && (r_offx == '0);
            r_last <= (r_offx == w_sx - SC_W'(1)) && (r_rib == w_sy - SC_W'(1));
            if (r_offx == w_sx - SC_W'(1)) begin
                r_offx <= '0;
                if (11'(r_col) == w_tw - 11'd1) begin
                    r_col <= '0;
                    if (r_rib == w_sy - SC_W'(1)) begin
                        r_rib <= '0;
                        r_trow <= (11'(r_trow) == w_th - 11'd1) ? 10'd0 : r_trow + 10'd1;
                    end else begin
                        r_rib <= r_rib + SC_W'(1);
                    end
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end else begin
                r_offx <= r_offx + SC_W'(1);
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pr <= i_red * i_alpha;
            r_pg <= i_green * i_alpha;
            r_pb <= i_blue * i_alpha;
            r_pa <= i_alpha;
        end
    end
    awbd_sum_ram u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_bcol), .i_wdata(w_wd),
        .i_raddr(r_col), .o_rdata(w_rd)
    );
    always_comb begin
        if (r_first) begin
            w_wd = '{red: SUM_W'(r_pr), green: SUM_W'(r_pg), blue: SUM_W'(r_pb),
                     alpha: ASUM_W'(r_pa)};
        end else begin
            w_wd.red = w_rd.red + SUM_W'(r_pr);
            w_wd.green = w_rd.green + SUM_W'(r_pg);
            w_wd.blue = w_rd.blue + SUM_W'(r_pb);
            w_wd.alpha = w_rd.alpha + ASUM_W'(r_pa);
        end
    end
    assign w_we = (r_state == ST_READ);
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) r_sum <= w_wd;
    end
    assign w_cov = (r_sum.alpha != '0) && ({r_sum.alpha, 16'd0} >= {2'd0, r_rhs[31:0]})
                   && !r_rhs[33] && !r_rhs[32];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_stage <= 1'b0;
        else r_stage <= (r_state == ST_READ) && r_last;
    end
    assign w_div_start = r_stage && w_cov;
    awbd_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start), .i_sums(r_sum),
        .o_done(w_div_done), .o_red(w_dr), .o_green(w_dg), .o_blue(w_db)
    );
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done_hold <= 1'b0;
        else if (r_state == ST_OUT && w_out_free) r_done_hold <= 1'b0;
        else if (w_div_done || (r_stage && !w_cov)) r_done_hold <= 1'b1;
        if (r_stage) r_res_cov <= w_cov;
    end
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_READ;
            ST_READ: n_state = r_last ? ST_DIV : ST_IDLE;
            ST_DIV: if (r_done_hold) n_state = ST_OUT;
            ST_OUT: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (r_state == ST_OUT && w_out_free) begin
            o_valid <= 1'b1;
            o_out_red <= r_res_cov ? w_dr : 8'd0;
            o_out_green <= r_res_cov ? w_dg : 8'd0;
            o_out_blue <= r_res_cov ? w_db : 8'd0;
            o_out_alpha <= r_res_cov ? 8'd255 : 8'd0;
            o_out_column <= 10'(r_bcol);
            o_out_row <= r_brow;
            o_frame_end <= r_bend;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end
    `AWB_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != ST_IDLE, !w_accept)
    `AWB_ASSERT_NEXT(a_read_follows, i_clk, i_rst_n, w_accept, r_state == ST_READ)
    `AWB_ASSERT_IMPL(a_div_only_in_div, i_clk, i_rst_n, w_div_start, r_state == ST_DIV)
endmodule
